FILE: sv/som_pkg.sv
// Shared constants, codes and command/status types of the map training unit.
`default_nettype none
package som_pkg;

    localparam int MAP_SIDE = 8;
    localparam int DIMS     = 3;
    localparam int NEURONS  = MAP_SIDE * MAP_SIDE;
    localparam int WDEPTH   = NEURONS * DIMS;

    localparam int AW     = $clog2(WDEPTH);
    localparam int NW     = $clog2(NEURONS);
    localparam int SW     = $clog2(MAP_SIDE);
    localparam int CW     = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int DIST_W = 32 + ((DIMS > 1) ? $clog2(DIMS) : 0);
    localparam int G2W    = $clog2(2 * (MAP_SIDE - 1) * (MAP_SIDE - 1) + 1);
    localparam int LIM_W  = 34;

    localparam int FUNC_W      = 2;
    localparam int NIDX_W      = 6;
    localparam int CIDX_W      = 3;
    localparam int DATA_W      = 16;
    localparam int STEP_W      = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [15:0]     RATE_START_RST   = 16'd6554;
    localparam logic [15:0]     RADIUS_START_RST = 16'd768;
    localparam logic [15:0]     DECAY_RST        = 16'd65208;
    localparam logic [19:0]     SORT_STEPS_RST   = 20'd1000;
    localparam logic [15:0]     RATE_FINAL_RST   = 16'd66;
    localparam logic [15:0]     RADIUS_FINAL_RST = 16'd1;
    localparam logic [STEP_W-1:0] STEP_MAX       = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_LOAD  = 2'd2,
        FUNC_TRAIN = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_START   = 3'd0,
        REG_RADIUS_START = 3'd1,
        REG_DECAY        = 3'd2,
        REG_SORT_STEPS   = 3'd3,
        REG_RATE_FINAL   = 3'd4,
        REG_RADIUS_FINAL = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic          accept;
        logic          issue;
        logic          upd;
        logic          first;
        logic          last;
        logic [AW-1:0] addr;
        logic [NW-1:0] neuron;
        logic [SW-1:0] row;
        logic [SW-1:0] col;
        logic [CW-1:0] comp;
        logic          train_init;
        logic          train_fin;
        logic          read_cap;
        logic          out_load;
    } som_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } som_stat_t;

endpackage
`default_nettype wire

FILE: sv/som_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module som_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/som_ctrl.sv
// Controller state machine that sequences item handling and the two training passes.
`default_nettype none
module som_ctrl
    import som_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_tvalid,
    input  wire logic [FUNC_W-1:0] in_tuser,
    output logic                   in_tready,
    input  wire som_stat_t         stat,
    output som_cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RESULT,
        S_T_INIT,
        S_T_DIST,
        S_T_DRAIN1,
        S_T_UPD,
        S_T_DRAIN2,
        S_T_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [NW-1:0] neuron_reg, neuron_next;
    logic [SW-1:0] row_reg, row_next;
    logic [SW-1:0] col_reg, col_next;
    logic [CW-1:0] comp_reg, comp_next;
    logic          last_comp;
    logic          last_neuron;
    func_t         func;

    always_comb
    begin
        func        = func_t'(in_tuser);
        in_tready   = (state_reg == S_IDLE);
        last_comp   = (comp_reg == CW'(DIMS - 1));
        last_neuron = (neuron_reg == NW'(NEURONS - 1));

        cmd            = '0;
        cmd.accept     = in_tvalid && in_tready;
        cmd.addr       = addr_reg;
        cmd.neuron     = neuron_reg;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        cmd.comp       = comp_reg;
        cmd.first      = (comp_reg == '0);
        cmd.last       = last_comp;
        cmd.upd        = (state_reg == S_T_UPD);

        state_next  = state_reg;
        addr_next   = addr_reg;
        neuron_next = neuron_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        comp_next   = comp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    unique case (func)
                        FUNC_READ:  state_next = S_RD_WAIT;
                        FUNC_TRAIN: state_next = S_T_INIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_T_INIT:
            begin
                cmd.train_init = 1'b1;
                addr_next      = '0;
                neuron_next    = '0;
                row_next       = '0;
                col_next       = '0;
                comp_next      = '0;
                state_next     = S_T_DIST;
            end
            S_T_DIST, S_T_UPD:
            begin
                cmd.issue = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (last_comp)
                begin
                    comp_next   = '0;
                    neuron_next = neuron_reg + 1'b1;
                    if (col_reg == SW'(MAP_SIDE - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (last_neuron)
                    begin
                        state_next = (state_reg == S_T_DIST) ? S_T_DRAIN1 : S_T_DRAIN2;
                    end
                end
                else
                begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            S_T_DRAIN1:
            begin
                addr_next   = '0;
                neuron_next = '0;
                row_next    = '0;
                col_next    = '0;
                comp_next   = '0;
                if (!stat.pipe_busy)
                begin
                    state_next = S_T_UPD;
                end
            end
            S_T_DRAIN2:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_T_FIN;
                end
            end
            S_T_FIN:
            begin
                cmd.train_fin = 1'b1;
                state_next    = S_RESULT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            addr_reg   <= '0;
            neuron_reg <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            comp_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            neuron_reg <= neuron_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            comp_reg   <= comp_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/som_dp.sv
// Datapath: weight memory, pattern, distance and update pipeline, registers and result.
`default_nettype none
module som_dp
    import som_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire som_cmd_t               cmd,
    output som_stat_t                   stat,
    input  wire logic [FUNC_W-1:0]      in_tuser,
    input  wire logic [IN_TDATA_W-1:0]  in_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        out_tvalid,
    input  wire logic                   out_tready,
    output logic [OUT_TDATA_W-1:0]      out_tdata
);

    typedef struct packed {
        logic          upd;
        logic          first;
        logic          last;
        logic [AW-1:0] addr;
        logic [NW-1:0] neuron;
        logic [SW-1:0] row;
        logic [SW-1:0] col;
        logic [CW-1:0] comp;
    } tag_t;

    function automatic logic [15:0] decay16(input logic [15:0] v, input logic [15:0] f);
        logic [32:0] s;
        s = 33'(v) * 33'(f) + 33'd32768;
        return s[31:16];
    endfunction

    logic [15:0]       rate_start_reg, radius_start_reg, decay_reg;
    logic [15:0]       rate_final_reg, radius_final_reg;
    logic [19:0]       sort_steps_reg;
    logic [15:0]       rate_now_reg, radius_now_reg;
    logic [STEP_W-1:0] step_reg;
    logic              sorting_reg;
    logic [15:0]       rate_use_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [15:0]       radius_use;

    logic [DATA_W-1:0] pattern_reg [DIMS];

    logic [NIDX_W-1:0]        in_neuron;
    logic [CIDX_W-1:0]        in_comp;
    logic [DATA_W-1:0]        in_data;
    logic                     ok_n, ok_c;
    logic [AW-1:0]            in_addr;
    func_t                    func;
    logic                     rd_ok_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [DATA_W-1:0]        ram_wdata, ram_rdata;

    logic                     v1_reg, v2_reg, v3_reg, v1_next;
    tag_t                     t1_reg, t2_reg, t3_reg, t0;
    logic signed [16:0]       diff1, diff2_reg;
    logic [DATA_W-1:0]        w2_reg, w3_reg;
    logic signed [16:0]       mul_a;
    logic signed [33:0]       mul3_next, mul3_reg;

    int                       dri, dci;
    logic [G2W-1:0]           g2;
    logic                     inhood;

    logic [31:0]              sq;
    logic [DIST_W-1:0]        total, acc_reg, best_d_reg;
    logic                     better;
    logic [NW-1:0]            best_idx_reg;
    logic [SW-1:0]            best_row_reg, best_col_reg;
    logic signed [33:0]       rsum;
    logic signed [18:0]       nw;
    logic [DATA_W-1:0]        nw_sat;

    logic [DATA_W-1:0]        res_weight_reg;
    logic [NIDX_W-1:0]        res_winner_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    always_comb
    begin
        func      = func_t'(in_tuser);
        in_neuron = in_tdata[5:0];
        in_comp   = in_tdata[8:6];
        in_data   = in_tdata[24:9];
        ok_n      = int'(in_neuron) < NEURONS;
        ok_c      = int'(in_comp) < DIMS;
        in_addr   = AW'(int'(in_neuron) * DIMS + int'(in_comp));
        cfg_ready = 1'b1;
        radius_use = (step_reg < sort_steps_reg) ? radius_now_reg : radius_final_reg;

        dri    = int'(cmd.row) - int'(best_row_reg);
        dci    = int'(cmd.col) - int'(best_col_reg);
        g2     = G2W'(dri * dri + dci * dci);
        inhood = LIM_W'({g2, 16'h0000}) < limit_reg;

        t0.upd    = cmd.upd;
        t0.first  = cmd.first;
        t0.last   = cmd.last;
        t0.addr   = cmd.addr;
        t0.neuron = cmd.neuron;
        t0.row    = cmd.row;
        t0.col    = cmd.col;
        t0.comp   = cmd.comp;
        v1_next   = cmd.issue && (!cmd.upd || inhood);

        diff1 = $signed({pattern_reg[t1_reg.comp][15], pattern_reg[t1_reg.comp]})
              - $signed({ram_rdata[15], ram_rdata});

        mul_a     = t2_reg.upd ? $signed({1'b0, rate_use_reg}) : diff2_reg;
        mul3_next = mul_a * diff2_reg;

        sq     = mul3_reg[31:0];
        total  = t3_reg.first ? DIST_W'(sq) : acc_reg + DIST_W'(sq);
        better = (t3_reg.neuron == '0) || (total < best_d_reg);

        rsum = mul3_reg + 34'sd32768;
        nw   = $signed({{3{w3_reg[15]}}, w3_reg}) + $signed({rsum[33], rsum[33:16]});
        if (nw > 19'sd32767)
        begin
            nw_sat = 16'h7FFF;
        end
        else if (nw < -19'sd32768)
        begin
            nw_sat = 16'h8000;
        end
        else
        begin
            nw_sat = nw[15:0];
        end

        if (v3_reg && t3_reg.upd)
        begin
            ram_we    = 1'b1;
            ram_waddr = t3_reg.addr;
            ram_wdata = nw_sat;
        end
        else
        begin
            ram_we    = cmd.accept && (func == FUNC_WRITE) && ok_n && ok_c;
            ram_waddr = in_addr;
            ram_wdata = in_data;
        end
        ram_raddr = cmd.issue ? cmd.addr : in_addr;

        stat.pipe_busy = v1_reg || v2_reg || v3_reg;
        stat.out_busy  = out_valid_reg && !out_tready;
        out_tvalid     = out_valid_reg;
        out_tdata      = out_data_reg;
    end

    som_ram #(
        .WIDTH(DATA_W),
        .DEPTH(WDEPTH)
    ) u_wram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_start_reg   <= RATE_START_RST;
            radius_start_reg <= RADIUS_START_RST;
            decay_reg        <= DECAY_RST;
            sort_steps_reg   <= SORT_STEPS_RST;
            rate_final_reg   <= RATE_FINAL_RST;
            radius_final_reg <= RADIUS_FINAL_RST;
            rate_now_reg     <= RATE_START_RST;
            radius_now_reg   <= RADIUS_START_RST;
            step_reg         <= '0;
            sorting_reg      <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RATE_START:
                    begin
                        rate_start_reg <= cfg_data[15:0];
                        rate_now_reg   <= cfg_data[15:0];
                    end
                    REG_RADIUS_START:
                    begin
                        radius_start_reg <= cfg_data[15:0];
                        radius_now_reg   <= cfg_data[15:0];
                    end
                    REG_DECAY:        decay_reg        <= cfg_data[15:0];
                    REG_SORT_STEPS:   sort_steps_reg   <= cfg_data;
                    REG_RATE_FINAL:   rate_final_reg   <= cfg_data[15:0];
                    REG_RADIUS_FINAL: radius_final_reg <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (cmd.train_init)
            begin
                sorting_reg <= step_reg < sort_steps_reg;
            end
            if (cmd.train_fin)
            begin
                if (sorting_reg)
                begin
                    rate_now_reg   <= decay16(rate_now_reg, decay_reg);
                    radius_now_reg <= decay16(radius_now_reg, decay_reg);
                end
                if (step_reg != STEP_MAX)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (func == FUNC_LOAD) && ok_c)
        begin
            pattern_reg[in_comp[CW-1:0]] <= in_data;
        end
        if (cmd.accept)
        begin
            rd_ok_reg <= ok_n && ok_c;
        end
        if (cmd.train_init)
        begin
            rate_use_reg <= (step_reg < sort_steps_reg) ? rate_now_reg : rate_final_reg;
            limit_reg    <= {32'(radius_use) * 32'(radius_use), 2'b00};
        end
        t1_reg    <= t0;
        t2_reg    <= t1_reg;
        t3_reg    <= t2_reg;
        diff2_reg <= diff1;
        w2_reg    <= ram_rdata;
        w3_reg    <= w2_reg;
        mul3_reg  <= mul3_next;
        if (v3_reg && !t3_reg.upd)
        begin
            acc_reg <= total;
            if (t3_reg.last && better)
            begin
                best_d_reg   <= total;
                best_idx_reg <= t3_reg.neuron;
                best_row_reg <= t3_reg.row;
                best_col_reg <= t3_reg.col;
            end
        end
        if (cmd.read_cap)
        begin
            res_weight_reg <= rd_ok_reg ? ram_rdata : '0;
            res_winner_reg <= '0;
        end
        if (cmd.train_fin)
        begin
            res_weight_reg <= '0;
            res_winner_reg <= NIDX_W'(best_idx_reg);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {6'b000000, step_reg, res_winner_reg, res_weight_reg};
        end
    end

endmodule
`default_nettype wire

FILE: sv/som_train_step_unit.sv
// Top level of the self-organizing map training unit.
//
//  Channel  Signals                          Payload
//  in       in_tvalid/in_tready              tuser: func; tdata: neuron, component, data
//  out      out_tvalid/out_tready            tdata: weight, winner, steps
//  cfg      cfg_valid/cfg_ready              cfg_index, cfg_data
//
// Write and load requests leave the block ready for the next request; a read request passes
// through a capture state and a result state before its result is offered. A train request
// walks the single weight memory once for the distance search and once for the update,
// draining the pipeline after each pass; the update drain is shorter when the last neuron
// lies outside the neighborhood. Reset clears control state and loads the register
// defaults; weights and pattern stay undefined until written. A stalled output holds the
// block in its result state.
`default_nettype none
module som_train_step_unit
    import som_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_tvalid,
    output logic                        in_tready,
    input  wire logic [FUNC_W-1:0]      in_tuser,   // [1:0] func
    input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] neuron_index, [8:6] component_index,
                                                    // [24:9] data_value, [31:25] zero
    output logic                        out_tvalid,
    input  wire logic                   out_tready,
    output logic [OUT_TDATA_W-1:0]      out_tdata,  // [15:0] weight_value, [21:16] winner_index,
                                                    // [41:22] steps_done, [47:42] zero
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    som_cmd_t  cmd;
    som_stat_t stat;

    som_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tvalid(in_tvalid),
        .in_tuser (in_tuser),
        .in_tready(in_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    som_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_tuser  (in_tuser),
        .in_tdata  (in_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_tvalid(out_tvalid),
        .out_tready(out_tready),
        .out_tdata (out_tdata)
    );

endmodule
`default_nettype wire

FILE: sv/som_checker.sv
// Port-level assertions for the training unit and their binding to the top level.
`default_nettype none
module som_checker
    import som_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_tvalid,
    input wire logic                   in_tready,
    input wire logic [FUNC_W-1:0]      in_tuser,
    input wire logic                   out_tvalid,
    input wire logic                   out_tready,
    input wire logic [OUT_TDATA_W-1:0] out_tdata,
    input wire logic                   cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> $stable(out_tdata))
        else $error("output request changed while stalled");

    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && (in_tuser == FUNC_WRITE || in_tuser == FUNC_LOAD)
        |=> in_tready)
        else $error("write or load request did not finish in one cycle");

    a_train_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && in_tuser == FUNC_TRAIN |=> !in_tready ##1 !in_tready)
        else $error("input accepted during a training step");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind som_train_step_unit som_checker u_som_checker (.*);
`default_nettype wire

FILE: dv/tb_som_train_step_unit.sv
// Self-checking testbench for the map training unit: weight, pattern and train requests.
`default_nettype none
module tb_som_train_step_unit;
    import som_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        func_t             op;
        logic [5:0]        neuron;
        logic [2:0]        comp;
        logic signed [15:0] value;
    } map_req_t;

    typedef struct {
        logic signed [15:0] weight;
        logic [5:0]         winner;
        logic [19:0]        steps;
    } map_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_tvalid = 1'b0;
    logic in_tready;
    logic [FUNC_W-1:0] in_tuser = '0;
    logic [IN_TDATA_W-1:0] in_tdata = '0;
    logic out_tvalid;
    logic out_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] out_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    som_train_step_unit dut (.*);

    always #5 clk = ~clk;

    map_req_t    req_queue[$];
    map_result_t expected_results[$];
    map_req_t    cur_req;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_cnt = 0;
    bit          rush = 1'b0;
    int          errors = 0;
    int          accepted = 0;
    int          trains = 0;
    int          reads = 0;
    int          idle_cycles = 0;

    // Shadow state of the map.
    logic signed [15:0] weights[WDEPTH];
    logic signed [15:0] pattern[DIMS];
    logic [15:0] rate_start_r, radius_start_r, decay_r, rate_final_r, radius_final_r;
    logic [19:0] sort_steps_r;
    logic [15:0] rate_now, radius_now;
    logic [19:0] step_count = '0;

    function automatic logic [15:0] decayed(logic [15:0] v);
        return 16'((longint'(v) * longint'(decay_r) + 32768) >> 16);
    endfunction

    function automatic logic [5:0] train_map();
        int          best;
        longint      best_d, d, diff, nw, lim, g2;
        int          dr, dc;
        bit          sorting;
        logic [15:0] rate, rad;
        best = 0;
        best_d = 0;
        sorting = step_count < sort_steps_r;
        rate = sorting ? rate_now : rate_final_r;
        rad = sorting ? radius_now : radius_final_r;
        lim = 4 * longint'(rad) * longint'(rad);
        for (int n = 0; n < NEURONS; n++)
        begin
            d = 0;
            for (int c = 0; c < DIMS; c++)
            begin
                diff = longint'(pattern[c]) - longint'(weights[n * DIMS + c]);
                d += diff * diff;
            end
            if (n == 0 || d < best_d)
            begin
                best_d = d;
                best = n;
            end
        end
        for (int n = 0; n < NEURONS; n++)
        begin
            dr = n / MAP_SIDE - best / MAP_SIDE;
            dc = n % MAP_SIDE - best % MAP_SIDE;
            g2 = dr * dr + dc * dc;
            if (g2 * 65536 < lim)
            begin
                for (int c = 0; c < DIMS; c++)
                begin
                    diff = longint'(pattern[c]) - longint'(weights[n * DIMS + c]);
                    nw = longint'(weights[n * DIMS + c])
                         + ((longint'(rate) * diff + 32768) >>> 16);
                    if (nw > 32767) nw = 32767;
                    if (nw < -32768) nw = -32768;
                    weights[n * DIMS + c] = 16'(nw);
                end
            end
        end
        if (sorting)
        begin
            rate_now = decayed(rate_now);
            radius_now = decayed(radius_now);
        end
        if (step_count != STEP_MAX) step_count++;
        return 6'(best);
    endfunction

    function automatic void map_apply(map_req_t r);
        map_result_t res;
        bit ok;
        ok = r.neuron < NEURONS && r.comp < DIMS;
        case (r.op)
            FUNC_WRITE: if (ok) weights[r.neuron * DIMS + r.comp] = r.value;
            FUNC_LOAD:  if (r.comp < DIMS) pattern[r.comp] = r.value;
            FUNC_READ:
            begin
                res.weight = ok ? weights[r.neuron * DIMS + r.comp] : 16'sd0;
                res.winner = '0;
                res.steps = step_count;
                expected_results.push_back(res);
                reads++;
            end
            default:
            begin
                res.weight = '0;
                res.winner = train_map();
                res.steps = step_count;
                expected_results.push_back(res);
                trains++;
            end
        endcase
    endfunction

    function automatic void reg_apply(logic [CFG_IDX_W-1:0] idx, logic [19:0] v);
        case (idx)
            REG_RATE_START:   begin rate_start_r = v[15:0]; rate_now = v[15:0]; end
            REG_RADIUS_START: begin radius_start_r = v[15:0]; radius_now = v[15:0]; end
            REG_DECAY:        decay_r = v[15:0];
            REG_SORT_STEPS:   sort_steps_r = v;
            REG_RATE_FINAL:   rate_final_r = v[15:0];
            REG_RADIUS_FINAL: radius_final_r = v[15:0];
            default: ;
        endcase
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tvalid <= 1'b0;
        end
        else
        begin
            if (in_tvalid && in_tready)
            begin
                map_apply(cur_req);
                accepted++;
            end
            if (!(in_tvalid && !in_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_tvalid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    cur_req = req_queue.pop_front();
                    in_tuser <= cur_req.op;
                    in_tdata <= {7'd0, cur_req.value, cur_req.comp, cur_req.neuron};
                    in_tvalid <= 1'b1;
                    send_gap = rush ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    in_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        if (!rst_n)
        begin
            out_tready <= 1'b0;
        end
        else
        begin
            if (out_tvalid && out_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_tdata[15:0] !== want.weight)
                    begin
                        errors++;
                        $display("%0t: weight_value expected %0d actual %0d", $time,
                                 want.weight, $signed(out_tdata[15:0]));
                    end
                    if (out_tdata[21:16] !== want.winner)
                    begin
                        errors++;
                        $display("%0t: winner_index expected %0d actual %0d", $time,
                                 want.winner, out_tdata[21:16]);
                    end
                    if (out_tdata[41:22] !== want.steps)
                    begin
                        errors++;
                        $display("%0t: steps_done expected %0d actual %0d", $time,
                                 want.steps, out_tdata[41:22]);
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_tready <= 1'b0;
            end
            else if (out_tvalid && out_tready || !out_tvalid && recv_gap == 0)
            begin
                recv_gap = rush ? 0 : $urandom_range(0, 10);
                out_tready <= (recv_gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_tready <= (recv_gap == 0);
            end
            else
            begin
                out_tready <= 1'b1;
            end
        end
    end

    // Watchdog on forward progress.
    always @(posedge clk)
    begin
        if (in_tvalid && in_tready || out_tvalid && out_tready || cfg_valid && cfg_ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tb_som_train_step_unit: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        reg_apply(idx, v);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (req_queue.size() > 0 || in_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] rs, logic [15:0] rds, logic [15:0] dk,
                            logic [19:0] ss, logic [15:0] rf, logic [15:0] rdf);
        write_reg(REG_RATE_START, 20'(rs));
        write_reg(REG_RADIUS_START, 20'(rds));
        write_reg(REG_DECAY, 20'(dk));
        write_reg(REG_SORT_STEPS, ss);
        write_reg(REG_RATE_FINAL, 20'(rf));
        write_reg(REG_RADIUS_FINAL, 20'(rdf));
    endtask

    task automatic queue_req(func_t op, int n, int c, int v);
        map_req_t r;
        r.op = op;
        r.neuron = 6'(n);
        r.comp = 3'(c);
        r.value = 16'(v);
        req_queue.push_back(r);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 7))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_random(int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                queue_req(FUNC_WRITE, $urandom_range(0, 63),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, DIMS - 1),
                          pick_value());
            else if (sel < 60)
                queue_req(FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 7),
                          $urandom_range(0, 65535));
            else if (sel < 83)
                queue_req(FUNC_LOAD, $urandom_range(0, 63),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, DIMS - 1),
                          pick_value());
            else
                queue_req(FUNC_TRAIN, $urandom_range(0, 63), $urandom_range(0, 7),
                          $urandom_range(0, 65535));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        set_regs(RATE_START_RST, RADIUS_START_RST, DECAY_RST, 20'd6, 16'd1000, 16'd300);
        write_reg(REG_SPARE_6, 20'hFFFFF);
        write_reg(REG_SPARE_7, 20'h12345);

        // Fill every weight and pattern entry before anything reads them.
        for (int n = 0; n < NEURONS; n++)
            for (int c = 0; c < DIMS; c++)
                queue_req(FUNC_WRITE, n, c, pick_value());
        for (int c = 0; c < DIMS; c++)
            queue_req(FUNC_LOAD, 0, c, pick_value());
        queue_req(FUNC_WRITE, 0, 0, 32767);
        queue_req(FUNC_WRITE, 63, 2, -32768);
        queue_req(FUNC_READ, 0, 0, 0);
        queue_req(FUNC_READ, 63, 2, 0);
        queue_req(FUNC_WRITE, 5, 3, 1234);
        queue_req(FUNC_WRITE, 5, 7, -1);
        queue_req(FUNC_READ, 5, 3, 0);
        queue_req(FUNC_READ, 42, 7, -1);
        queue_req(FUNC_LOAD, 63, 6, 32767);
        queue_req(FUNC_LOAD, 21, 1, -32768);
        queue_req(FUNC_LOAD, 42, 2, 32767);
        for (int i = 0; i < 8; i++)
            queue_req(FUNC_TRAIN, 0, 0, 0);
        queue_req(FUNC_READ, 27, 1, 0);
        drain();

        // Defaults, with bursty traffic and a long output stall.
        rush = 1'b1;
        set_regs(RATE_START_RST, RADIUS_START_RST, DECAY_RST, SORT_STEPS_RST,
                 RATE_FINAL_RST, RADIUS_FINAL_RST);
        hold_cnt <= 1500;
        queue_random(250);
        drain();
        rush = 1'b0;

        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(250);
        drain();

        set_regs(16'h0, 16'h0, 16'h0, 20'h0, 16'h0, 16'h0);
        queue_random(200);
        drain();

        set_regs(16'd40000, 16'd2000, 16'd0, 20'd3, 16'hFFFF, 16'h0);
        queue_random(200);
        drain();

        set_regs(16'(pick_value()), 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 65535)),
                 20'($urandom_range(0, 60)), 16'(pick_value()), 16'($urandom_range(0, 4000)));
        queue_random(250);
        drain();

        set_regs(16'hFFFF, 16'd1, 16'd65000, 20'd30, 16'd1, 16'h3000);
        queue_random(200);
        drain();

        $display("Covered %0d accepted requests, %0d train steps and %0d weight reads",
                 accepted, trains, reads);
        $display("over seven register settings, including all-zero and all-ones extremes.");
        if (errors == 0)
            $display("tb_som_train_step_unit: PASS");
        else
            $display("tb_som_train_step_unit: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
sv/som_pkg.sv
sv/som_ram.sv
sv/som_ctrl.sv
sv/som_dp.sv
sv/som_train_step_unit.sv
sv/som_checker.sv
dv/tb_som_train_step_unit.sv
